>>> hw/rtl/bnr_pkg.sv
// ----------------------------------------------------------------------------
// Bezier Newton reparameterisation package
// Shared payload types, register indexes and fixed-point helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package bnr_pkg;

  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int PARAM_FRAC_BITS_DEF = 30;
  localparam int NUM_REGS            = 8;
  localparam int QUOT_BITS           = 35;  // quotient cap is 2^34

  typedef enum logic [2:0] {
    REG_C0X = 3'd0, REG_C0Y = 3'd1, REG_C1X = 3'd2, REG_C1Y = 3'd3,
    REG_C2X = 3'd4, REG_C2Y = 3'd5, REG_C3X = 3'd6, REG_C3Y = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] param_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] param_out;
    logic               denom_zero;
    logic               saturated;
  } out_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647)       sat32 = 32'sh7fffffff;
    else if (v < -36'sd2147483648) sat32 = 32'sh80000000;
    else                           sat32 = v[31:0];
  endfunction

  function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) sadd64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else                sadd64 = s[63:0];
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/bnr_lerp.sv
// ----------------------------------------------------------------------------
// Bezier lerp stage
// One registered de Casteljau step: a + floor((b-a)*t / 2^PF), clipped.
// ----------------------------------------------------------------------------
`default_nettype none
module bnr_lerp #(
  parameter int PARAM_FRAC_BITS = bnr_pkg::PARAM_FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  input  wire logic signed [31:0] t,
  output logic signed [31:0]      v_r
);
  logic signed [32:0] diff;
  logic signed [64:0] prod;
  logic signed [64:0] shf;
  logic signed [65:0] sum;
  logic signed [31:0] v_nxt;

  always_comb begin
    diff = 33'(b) - 33'(a);
    prod = 65'(diff) * 65'(t);
    shf  = prod >>> PARAM_FRAC_BITS;
    sum  = 66'(a) + 66'(shf);
    if (sum > 66'sd2147483647)       v_nxt = 32'sh7fffffff;
    else if (sum < -66'sd2147483648) v_nxt = 32'sh80000000;
    else                             v_nxt = sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) v_r <= v_nxt;
  end
endmodule
`default_nettype wire

>>> hw/rtl/bnr_div.sv
// ----------------------------------------------------------------------------
// Bezier fractional divider
// Pipelined restoring divider, one quotient bit per stage, capped at 2^34.
// ----------------------------------------------------------------------------
`default_nettype none
module bnr_div #(
  parameter int PARAM_FRAC_BITS = bnr_pkg::PARAM_FRAC_BITS_DEF,
  parameter type SIDE_T = logic
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_vld,
  input  wire logic [63:0] num,
  input  wire logic [63:0] den,
  input  wire SIDE_T       side_in,
  output logic             out_vld,
  output logic [bnr_pkg::QUOT_BITS-1:0] quot,
  output SIDE_T            side_out
);
  import bnr_pkg::*;
  // integer quotient bits below the cap, then PARAM_FRAC_BITS fraction bits
  localparam int IB    = QUOT_BITS - PARAM_FRAC_BITS;
  localparam int STEPS = QUOT_BITS;
  localparam int LW    = 64 + IB;
  localparam logic [STEPS-1:0] CAP = {1'b1, {(STEPS-1){1'b0}}};

  logic [STEPS:0]        vld_r;
  logic [STEPS-1:0]      n_r   [STEPS+1];
  logic [63:0]           d_r   [STEPS+1];
  logic [64:0]           rem_r [STEPS+1];
  logic [STEPS-1:0]      q_r   [STEPS+1];
  logic                  big_r [STEPS+1];
  SIDE_T                 s_r   [STEPS+1];
  logic [LW-1:0]         lim;

  always_comb begin
    // integer part above the cap: flag it now, the bits below are then dropped
    lim      = (LW'(den) << (IB - 1)) + LW'(den);
    big_r[0] = LW'(num) >= lim;
    n_r[0]   = {num[IB-1:0], {PARAM_FRAC_BITS{1'b0}}};
    d_r[0]   = den;
    rem_r[0] = 65'(num >> IB);
    q_r[0]   = '0;
    s_r[0]   = side_in;
    vld_r[0] = in_vld;
  end

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    logic [65:0] sh;
    logic [65:0] df;
    logic        ge;
    always_comb begin
      sh = {rem_r[g], n_r[g][STEPS-1]};
      df = sh - {2'b00, d_r[g]};
      ge = !df[65];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[g+1] <= 1'b0;
      else        vld_r[g+1] <= vld_r[g];
      n_r[g+1]   <= n_r[g] << 1;
      d_r[g+1]   <= d_r[g];
      rem_r[g+1] <= ge ? df[64:0] : sh[64:0];
      q_r[g+1]   <= {q_r[g][STEPS-2:0], ge};
      big_r[g+1] <= big_r[g];
      s_r[g+1]   <= s_r[g];
    end
  end

  logic [STEPS-1:0] qf;
  assign qf       = q_r[STEPS];
  assign out_vld  = vld_r[STEPS];
  assign side_out = s_r[STEPS];
  assign quot = (big_r[STEPS] || qf > CAP) ? CAP : qf;
endmodule
`default_nettype wire

>>> hw/rtl/bezier_newton_reparam_step.sv
// ----------------------------------------------------------------------------
// Bezier Newton reparameterisation step
// One Newton refinement of a curve parameter against a cubic Bezier.
// ----------------------------------------------------------------------------
//  channel | direction | handshake
//  in_     | in        | in_start, accepted when in_busy is low
//  out_    | out       | out_strobe, one cycle, cannot be held off
//  cfg_    | in        | APB write, 8 words at 4*i
// One item per cycle; in_busy is tied low. out_strobe rises at the end of the
// pipeline: three lerp stages, one product stage, one sum stage, 35 divider
// stages of one quotient bit each, output register. Reset clears all valid
// bits and the control points. No stalls exist anywhere.
`default_nettype none
module bezier_newton_reparam_step #(
  parameter int COORD_FRAC_BITS = bnr_pkg::COORD_FRAC_BITS_DEF,
  parameter int PARAM_FRAC_BITS = bnr_pkg::PARAM_FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_start,
  output logic                   in_busy,
  input  wire bnr_pkg::in_item_t in_data,
  output logic                   out_strobe,
  output bnr_pkg::out_item_t     out_data,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [4:0]        cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);
  import bnr_pkg::*;

  logic signed [31:0] regs_r [NUM_REGS];
  logic               wr;
  assign cfg_pready = 1'b1;
  assign in_busy    = 1'b0;
  assign wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) regs_r[i] <= '0;
    end else if (wr) begin
      regs_r[cfg_paddr[4:2]] <= cfg_pwdata;
    end
  end
  assign cfg_prdata = (cfg_paddr[1:0] == 2'b00) ? regs_r[cfg_paddr[4:2]] : '0;

  // derivative control vertices (static between writes)
  logic signed [31:0] d1 [2][3];
  logic signed [31:0] d2 [2][2];
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      for (int i = 0; i < 3; i++)
        d1[a][i] = sat32(36'(regs_r[2*i+2+a]) * 36'sd3 - 36'(regs_r[2*i+a]) * 36'sd3);
      for (int i = 0; i < 2; i++)
        d2[a][i] = sat32(36'(d1[a][i+1]) * 36'sd2 - 36'(d1[a][i]) * 36'sd2);
    end
  end

  // stage valid and carried fields across the three lerp levels
  logic [3:0]         v_r;
  in_item_t           it_r [4];
  assign it_r[0] = in_data;
  assign v_r[0]  = in_start;
  always_ff @(posedge clk) begin
    if (!rst_n) v_r[3:1] <= '0;
    else        v_r[3:1] <= v_r[2:0];
    it_r[1] <= it_r[0];
    it_r[2] <= it_r[1];
    it_r[3] <= it_r[2];
  end

  // per axis: level1 has 3 (Q) + 2 (Q') + 1 (Q''), level2 2 + 1, level3 1
  logic signed [31:0] l1 [2][6];
  logic signed [31:0] l2 [2][3];
  logic signed [31:0] l3 [2];
  logic signed [31:0] q1h [2];
  logic signed [31:0] q2h [2][2];
  for (genvar a = 0; a < 2; a++) begin : g_ax
    for (genvar i = 0; i < 3; i++) begin : g_l1q
      bnr_lerp #(.PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_l (.clk, .en(1'b1),
        .a(regs_r[2*i+a]), .b(regs_r[2*i+2+a]), .t(it_r[0].param_in), .v_r(l1[a][i]));
    end
    for (genvar i = 0; i < 2; i++) begin : g_l1d
      bnr_lerp #(.PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_l (.clk, .en(1'b1),
        .a(d1[a][i]), .b(d1[a][i+1]), .t(it_r[0].param_in), .v_r(l1[a][3+i]));
    end
    bnr_lerp #(.PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_l1dd (.clk, .en(1'b1),
      .a(d2[a][0]), .b(d2[a][1]), .t(it_r[0].param_in), .v_r(l1[a][5]));
    for (genvar i = 0; i < 2; i++) begin : g_l2q
      bnr_lerp #(.PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_l (.clk, .en(1'b1),
        .a(l1[a][i]), .b(l1[a][i+1]), .t(it_r[1].param_in), .v_r(l2[a][i]));
    end
    bnr_lerp #(.PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_l2d (.clk, .en(1'b1),
      .a(l1[a][3]), .b(l1[a][4]), .t(it_r[1].param_in), .v_r(l2[a][2]));
    bnr_lerp #(.PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_l3q (.clk, .en(1'b1),
      .a(l2[a][0]), .b(l2[a][1]), .t(it_r[2].param_in), .v_r(l3[a]));
    // hold Q' and Q'' one and two stages to line up with Q
    always_ff @(posedge clk) begin
      q1h[a]    <= l2[a][2];
      q2h[a][0] <= l1[a][5];
      q2h[a][1] <= q2h[a][0];
    end
  end

  // products: stage 4
  logic signed [32:0] dl [2];
  logic signed [63:0] p_r [6];
  logic               v4_r, v5_r;
  in_item_t           it4_r, it5_r;
  logic signed [65:0] pr [6];
  always_comb begin
    dl[0] = 33'(l3[0]) - 33'(it_r[3].point_x);
    dl[1] = 33'(l3[1]) - 33'(it_r[3].point_y);
    pr[0] = (66'(dl[0]) * 66'(q1h[0])) >>> COORD_FRAC_BITS;
    pr[1] = (66'(dl[1]) * 66'(q1h[1])) >>> COORD_FRAC_BITS;
    pr[2] = (66'(q1h[0]) * 66'(q1h[0])) >>> COORD_FRAC_BITS;
    pr[3] = (66'(q1h[1]) * 66'(q1h[1])) >>> COORD_FRAC_BITS;
    pr[4] = (66'(dl[0]) * 66'(q2h[0][1])) >>> COORD_FRAC_BITS;
    pr[5] = (66'(dl[1]) * 66'(q2h[1][1])) >>> COORD_FRAC_BITS;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0; v5_r <= 1'b0;
    end else begin
      v4_r <= v_r[3]; v5_r <= v4_r;
    end
    for (int i = 0; i < 6; i++) p_r[i] <= pr[i][63:0];
    it4_r <= it_r[3];
    it5_r <= it4_r;
  end

  // sums: stage 5
  logic signed [63:0] num_r, den_r;
  always_ff @(posedge clk) begin
    num_r <= sadd64(p_r[0], p_r[1]);
    den_r <= sadd64(sadd64(sadd64(p_r[2], p_r[3]), p_r[4]), p_r[5]);
  end

  typedef struct packed {
    logic signed [31:0] u;
    logic               dz;
    logic               neg;
  } side_t;
  side_t sd_in, sd_out;
  logic  dv;
  logic [QUOT_BITS-1:0] qq;
  logic [63:0] nm, dm;
  always_comb begin
    nm = num_r[63] ? 64'(0) - num_r : num_r;
    dm = den_r[63] ? 64'(0) - den_r : den_r;
    sd_in.u   = it5_r.param_in;
    sd_in.dz  = (den_r == '0);
    sd_in.neg = num_r[63] ^ den_r[63];
  end

  bnr_div #(.PARAM_FRAC_BITS(PARAM_FRAC_BITS), .SIDE_T(side_t)) u_div (
    .clk, .rst_n, .in_vld(v5_r), .num(nm), .den(sd_in.dz ? 64'd1 : dm),
    .side_in(sd_in), .out_vld(dv), .quot(qq), .side_out(sd_out));

  logic signed [36:0] res;
  out_item_t          o_nxt;
  always_comb begin
    res = sd_out.neg ? 37'(sd_out.u) + 37'(qq) : 37'(sd_out.u) - 37'(qq);
    o_nxt.denom_zero = sd_out.dz;
    if (sd_out.dz) begin
      o_nxt.param_out = sd_out.u;
      o_nxt.saturated = 1'b0;
    end else begin
      o_nxt.param_out = sat32(res[35:0]);
      o_nxt.saturated = (res > 37'sd2147483647) || (res < -37'sd2147483648);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe <= 1'b0;
    else        out_strobe <= dv;
    out_data <= o_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.denom_zero |-> !out_data.saturated)
    else $error("zero denominator reported as saturated");
  assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |=> v5_r)
    else $error("valid lost between product and sum stages");
  assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("strobe after reset");
endmodule
`default_nettype wire

>>> tb/sv/bezier_newton_reparam_step_tb.sv
// ----------------------------------------------------------------------------
// Bezier Newton reparameterisation step testbench
// Drives directed and random points through the block under several control
// point settings and checks every result against a bit-exact predictor or a typed expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module bezier_newton_reparam_step_tb;
  import bnr_pkg::*;

  localparam int CF = 16;
  localparam int PF = 30;
  localparam int DRAIN = 120;
  localparam logic [63:0] QCAP = 64'd1 << 34;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_start = 1'b0;
  logic in_busy;
  in_item_t in_data = '0;
  logic out_strobe;
  out_item_t out_data;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  // typed expectation travelling with a directed item
  logic drv_typed = 1'b0;
  out_item_t drv_typed_res = '0;

  logic signed [31:0] ctrl_pt [8];
  out_item_t param_expq [$];
  int mismatches = 0;
  bit stray = 0;

  bezier_newton_reparam_step i_dut (
    .clk(clk), .rst_n(rst_n), .in_start(in_start), .in_busy(in_busy),
    .in_data(in_data), .out_strobe(out_strobe), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic signed [63:0] clip32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [63:0] add_clip64(logic signed [63:0] a,
                                                    logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] lerp_q(logic signed [63:0] a,
      logic signed [63:0] b, logic signed [63:0] t);
    logic signed [63:0] p;
    p = (b - a) * t;
    return clip32(a + (p >>> PF));
  endfunction

  function automatic logic [63:0] mag(logic signed [63:0] v);
    return v[63] ? 64'd0 - v : v;
  endfunction

  // one Newton step on the parameter for point (px, py)
  function automatic out_item_t refine_param(in_item_t it);
    logic signed [63:0] c [4], d1 [3], d2 [2], q [2], q1 [2], q2 [2], dl [2];
    logic signed [63:0] u, num, den, step, res;
    logic [63:0] n, d, qm;
    logic [127:0] wide;
    out_item_t r;
    u = it.param_in;
    for (int ax = 0; ax < 2; ax++) begin
      for (int i = 0; i < 4; i++) c[i] = ctrl_pt[2 * i + ax];
      for (int i = 0; i < 3; i++) d1[i] = clip32((c[i + 1] - c[i]) * 3);
      for (int i = 0; i < 2; i++) d2[i] = clip32((d1[i + 1] - d1[i]) * 2);
      for (int i = 1; i <= 3; i++)
        for (int j = 0; j <= 3 - i; j++) c[j] = lerp_q(c[j], c[j + 1], u);
      for (int i = 1; i <= 2; i++)
        for (int j = 0; j <= 2 - i; j++) d1[j] = lerp_q(d1[j], d1[j + 1], u);
      d2[0] = lerp_q(d2[0], d2[1], u);
      q[ax] = c[0];
      q1[ax] = d1[0];
      q2[ax] = d2[0];
    end
    dl[0] = q[0] - 64'(signed'(it.point_x));
    dl[1] = q[1] - 64'(signed'(it.point_y));
    num = add_clip64((dl[0] * q1[0]) >>> CF, (dl[1] * q1[1]) >>> CF);
    den = add_clip64((q1[0] * q1[0]) >>> CF, (q1[1] * q1[1]) >>> CF);
    den = add_clip64(den, (dl[0] * q2[0]) >>> CF);
    den = add_clip64(den, (dl[1] * q2[1]) >>> CF);
    r = '0;
    if (den == 0) begin
      r.param_out = it.param_in;
      r.denom_zero = 1'b1;
      return r;
    end
    n = mag(num);
    d = mag(den);
    if (n / d > (QCAP >> PF)) begin
      qm = QCAP;
    end else begin
      wide = {64'd0, n} << PF;
      wide = wide / {64'd0, d};
      qm = (wide > {64'd0, QCAP}) ? QCAP : wide[63:0];
    end
    step = qm;
    if (num[63] != den[63]) step = -step;
    res = u - step;
    r.saturated = (clip32(res) != res);
    r.param_out = clip32(res);
    return r;
  endfunction

  // shadow the control registers and record expectations at each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) ctrl_pt[i] <= '0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)
        ctrl_pt[cfg_paddr[4:2]] <= cfg_pwdata;
      if (in_start && !in_busy)
        param_expq.insert(param_expq.size(),
                          drv_typed ? drv_typed_res : refine_param(in_data));
    end
  end

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_strobe) begin
      if (param_expq.size() == 0) begin
        stray = 1;
        if (mismatches < 10) $display("unexpected result %h", out_data);
        mismatches++;
      end else begin
        e = param_expq.pop_front();
        if (out_data.param_out !== e.param_out || out_data.denom_zero !== e.denom_zero ||
            out_data.saturated !== e.saturated) begin
          if (mismatches < 10)
            $display("mismatch: exp %h/%b/%b got %h/%b/%b", e.param_out, e.denom_zero,
                     e.saturated, out_data.param_out, out_data.denom_zero,
                     out_data.saturated);
          mismatches++;
        end
      end
    end
  end

  // setup then access; the caller drops psel after the last transfer
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
  endtask

  task automatic set_curve(logic [31:0] v [8]);
    for (int i = 0; i < 8; i++) write_reg(reg_idx_t'(i), v[i]);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // let the pipeline empty before touching the registers
  task automatic wait_idle();
    in_start <= 1'b0;
    drv_typed <= 1'b0;
    @(posedge clk);
    while (param_expq.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic send_point(in_item_t it, bit typed, out_item_t tr, bit gaps);
    if (gaps && $urandom_range(99) < 39) begin
      in_start <= 1'b0;
      @(posedge clk);
    end
    in_start <= 1'b1;
    in_data <= it;
    drv_typed <= typed;
    drv_typed_res <= tr;
    @(posedge clk);
    while (in_busy) @(posedge clk);
  endtask

  function automatic in_item_t rand_point(bit shaped);
    in_item_t it;
    if (shaped) begin
      it.point_x = $signed($urandom_range(32'h00400000)) - 32'sh00200000;
      it.point_y = $signed($urandom_range(32'h00400000)) - 32'sh00200000;
      it.param_in = $urandom_range(32'h40000000);
    end else begin
      it.point_x = $urandom;
      it.point_y = $urandom;
      it.param_in = $urandom;
    end
    return it;
  endfunction

  typedef struct {
    logic [31:0] px, py, u;
    bit typed;
    logic [31:0] res;
  } dir_row_t;

  dir_row_t zero_rows [8] = '{
    '{32'h0, 32'h0, 32'h0, 1, 32'h0},
    '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1, 32'h7fffffff},
    '{32'h80000000, 32'h80000000, 32'h80000000, 1, 32'h80000000},
    '{32'h7fffffff, 32'h80000000, 32'h40000000, 1, 32'h40000000},
    '{32'h12345678, 32'hfedcba98, 32'hc0000000, 1, 32'hc0000000},
    '{32'h80000000, 32'h7fffffff, 32'h20000000, 1, 32'h20000000},
    '{32'hffffffff, 32'h00000001, 32'h7fffffff, 1, 32'h7fffffff},
    '{32'h00010000, 32'h00010000, 32'h60000000, 1, 32'h60000000}
  };

  dir_row_t curve_rows [12] = '{
    '{32'h0, 32'h0, 32'h0, 0, 32'h0},
    '{32'h00010000, 32'h00010000, 32'h40000000, 0, 32'h0},
    '{32'h00020000, 32'h00010000, 32'h20000000, 0, 32'h0},
    '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 32'h0},
    '{32'h80000000, 32'h80000000, 32'h80000000, 0, 32'h0},
    '{32'h80000000, 32'h7fffffff, 32'hc0000000, 0, 32'h0},
    '{32'h00008000, 32'h00030000, 32'h50000000, 0, 32'h0},
    '{32'h00020000, 32'h00000000, 32'h10000000, 0, 32'h0},
    '{32'h00000000, 32'h00020000, 32'h38000000, 0, 32'h0},
    '{32'h7fffffff, 32'h80000000, 32'h00000001, 0, 32'h0},
    '{32'hfff00000, 32'h00100000, 32'hffffffff, 0, 32'h0},
    '{32'h00018000, 32'h00008000, 32'h60000000, 0, 32'h0}
  };

  task automatic run_rows(dir_row_t rows [], bit gaps);
    in_item_t it;
    out_item_t tr;
    foreach (rows[i]) begin
      it.point_x = rows[i].px;
      it.point_y = rows[i].py;
      it.param_in = rows[i].u;
      tr.param_out = rows[i].res;
      tr.denom_zero = 1'b1;
      tr.saturated = 1'b0;
      send_point(it, rows[i].typed, tr, gaps);
    end
  endtask

  initial begin
    logic [31:0] cv [8];
    dir_row_t rows [];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers still at reset: every denominator is zero
    rows = zero_rows;
    run_rows(rows, 1);
    wait_idle();

    cv = '{32'h0, 32'h0, 32'h00010000, 32'h00020000,
           32'h00020000, 32'h00020000, 32'h00030000, 32'h0};
    set_curve(cv);
    rows = curve_rows;
    run_rows(rows, 1);
    wait_idle();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: cv = '{default: 32'h7fffffff};
        1: cv = '{default: 32'h80000000};
        2: cv = '{32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                  32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000};
        3: for (int i = 0; i < 8; i++) cv[i] = $urandom;
        default:
          for (int i = 0; i < 8; i++)
            cv[i] = $signed($urandom_range(32'h00080000)) - 32'sh00040000;
      endcase
      set_curve(cv);
      // phase 5 runs flat out with no gaps
      for (int k = 0; k < 95; k++)
        send_point(rand_point($urandom_range(99) < 75), 0, '0, ph != 5);
      wait_idle();
    end

    if (mismatches == 0 && !stray) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
